// File: rtl/mutual_nearest_match_filter_defines.svh
// Assertion macros for the mutual nearest match filter.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef MUTUAL_NEAREST_MATCH_FILTER_DEFINES_SVH
`define MUTUAL_NEAREST_MATCH_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNM_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNM_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// File: rtl/mnm_pkg.sv
// Shared types and constants for the mutual nearest match filter.
// Used by the controller, the datapath and the top level; no dependencies.
package mnm_pkg;

    localparam int SCORE_W        = 24;
    localparam int IDX_OUT_W      = 10;
    localparam int DEF_MAX_POINTS = 1024;

    localparam logic signed [SCORE_W-1:0] THR_RESET = -24'sd9431;

    localparam logic CMD_SCORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [SCORE_W-1:0] score;
        logic                      end_of_row;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]      row_index;
        logic [IDX_OUT_W-1:0]      col_index;
        logic signed [SCORE_W-1:0] match_score;
        logic                      matched;
        logic                      last_row;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_Q_ROW,
        ST_Q_COL
    } mnm_state_t;

    typedef struct packed {
        logic take_score;
        logic take_query;
        logic do_load;
        logic col_rd_query;
        logic load_out;
    } mnm_cmd_t;

    typedef struct packed {
        logic is_query;
        logic rows_zero;
        logic out_free;
    } mnm_status_t;

endpackage

// File: rtl/mnm_ctrl.sv
// Controller state machine of the mutual nearest match filter.
// Depends on mnm_pkg; drives the datapath through mnm_cmd_t.
module mnm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mnm_pkg::mnm_status_t status,
    output mnm_pkg::mnm_cmd_t    cmd
);
    import mnm_pkg::*;

    mnm_state_t state_reg;
    mnm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.is_query)
                    begin
                        cmd.take_query = 1'b1;
                        state_next     = status.rows_zero ? ST_Q_COL : ST_Q_ROW;
                    end
                    else
                    begin
                        cmd.take_score = 1'b1;
                        state_next     = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_Q_ROW:
            begin
                cmd.col_rd_query = 1'b1;
                state_next       = ST_Q_COL;
            end
            ST_Q_COL:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mnm_datapath.sv
// Datapath of the mutual nearest match filter: counters, row and column stores,
// threshold register and output register. Depends on mnm_pkg.
module mnm_datapath #(
    parameter int MAX_POINTS = mnm_pkg::DEF_MAX_POINTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mnm_pkg::in_item_t                  in_data,
    input  logic                               cfg_we,
    input  logic signed [mnm_pkg::SCORE_W-1:0] cfg_wdata,
    input  logic                               out_ready,
    output logic                               out_valid,
    output mnm_pkg::out_item_t                 out_data,
    input  mnm_pkg::mnm_cmd_t                  cmd,
    output mnm_pkg::mnm_status_t               status
);
    import mnm_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [IDX_W-1:0]          row_mem_col   [MAX_POINTS];
    logic signed [SCORE_W-1:0] row_mem_score [MAX_POINTS];
    logic [IDX_W-1:0]          col_mem_row   [MAX_POINTS];
    logic signed [SCORE_W-1:0] col_mem_score [MAX_POINTS];

    logic [CNT_W-1:0] rows_reg,   rows_next;
    logic [CNT_W-1:0] colpos_reg, colpos_next;
    logic [CNT_W-1:0] cols_reg,   cols_next;
    logic [CNT_W-1:0] qp_reg,     qp_next;

    logic signed [SCORE_W-1:0] thr_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;
    out_item_t                 out_data_next;

    in_item_t                  item_reg;
    logic signed [SCORE_W-1:0] rbest_score_reg;
    logic [IDX_W-1:0]          rbest_col_reg;
    logic [IDX_W-1:0]          col_rd_row_reg;
    logic signed [SCORE_W-1:0] col_rd_score_reg;
    logic [IDX_W-1:0]          row_rd_col_reg;
    logic signed [SCORE_W-1:0] row_rd_score_reg;
    logic [IDX_W-1:0]          q_row_reg;
    logic                      empty_reg;

    logic             new_matrix;
    logic [CNT_W-1:0] eff_r, eff_c, eff_cols, limit, c_after, q_r;
    logic             row_ok, col_ok, row_upd, col_upd;
    logic [IDX_W-1:0] c_idx, r_idx, col_rd_addr;
    logic             col_rd_en;
    logic [IDX_W-1:0]          row_wr_col;
    logic signed [SCORE_W-1:0] row_wr_score;
    logic                      matched;
    logic                      last_row;
    logic [IDX_W+IDX_OUT_W-1:0] row_wide, col_wide;

    always_comb
    begin
        new_matrix = (qp_reg != '0);
        eff_r      = new_matrix ? '0 : rows_reg;
        eff_c      = new_matrix ? '0 : colpos_reg;
        eff_cols   = new_matrix ? '0 : cols_reg;
        limit      = (eff_r == '0) ? CNT_W'(MAX_POINTS) : eff_cols;
        row_ok     = (eff_r < CNT_W'(MAX_POINTS));
        col_ok     = row_ok && (eff_c < limit);
        c_idx      = eff_c[IDX_W-1:0];
        r_idx      = eff_r[IDX_W-1:0];
        row_upd    = (eff_c == '0) || (item_reg.score > rbest_score_reg);
        col_upd    = (eff_r == '0) || (item_reg.score > col_rd_score_reg);
        c_after    = col_ok ? eff_c + CNT_W'(1) : eff_c;
        row_wr_col   = row_upd ? c_idx : rbest_col_reg;
        row_wr_score = row_upd ? item_reg.score : rbest_score_reg;
        q_r        = (qp_reg >= rows_reg) ? '0 : qp_reg;
        col_rd_en   = cmd.take_score || cmd.col_rd_query;
        col_rd_addr = cmd.take_score ? c_idx : row_rd_col_reg;
    end

    always_comb
    begin
        rows_next   = rows_reg;
        colpos_next = colpos_reg;
        cols_next   = cols_reg;
        qp_next     = qp_reg;
        if (cmd.do_load)
        begin
            qp_next     = '0;
            rows_next   = eff_r;
            colpos_next = c_after;
            cols_next   = eff_cols;
            if (row_ok && item_reg.end_of_row)
            begin
                rows_next   = eff_r + CNT_W'(1);
                colpos_next = '0;
                if (eff_r == '0)
                begin
                    cols_next = c_after;
                end
            end
        end
        else if (cmd.take_query && (rows_reg != '0))
        begin
            qp_next = q_r + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= '0;
            colpos_reg    <= '0;
            cols_reg      <= '0;
            qp_reg        <= '0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg   <= rows_next;
            colpos_reg <= colpos_next;
            cols_reg   <= cols_next;
            qp_reg     <= qp_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_score || cmd.take_query)
        begin
            item_reg  <= in_data;
            empty_reg <= (rows_reg == '0);
        end
        if (cmd.take_query)
        begin
            q_row_reg        <= q_r[IDX_W-1:0];
            row_rd_col_reg   <= row_mem_col[q_r[IDX_W-1:0]];
            row_rd_score_reg <= row_mem_score[q_r[IDX_W-1:0]];
        end
        if (col_rd_en)
        begin
            col_rd_row_reg   <= col_mem_row[col_rd_addr];
            col_rd_score_reg <= col_mem_score[col_rd_addr];
        end
        if (cmd.do_load && col_ok)
        begin
            rbest_col_reg         <= row_wr_col;
            rbest_score_reg       <= row_wr_score;
            row_mem_col[r_idx]    <= row_wr_col;
            row_mem_score[r_idx]  <= row_wr_score;
            if (col_upd)
            begin
                col_mem_row[c_idx]   <= r_idx;
                col_mem_score[c_idx] <= item_reg.score;
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        row_wide = {{IDX_OUT_W{1'b0}}, q_row_reg};
        col_wide = {{IDX_OUT_W{1'b0}}, row_rd_col_reg};
        matched  = (col_rd_row_reg == q_row_reg) && (row_rd_score_reg > thr_reg);
        last_row = ((CNT_W'(q_row_reg) + CNT_W'(1)) == rows_reg);
        if (empty_reg)
        begin
            out_data_next          = '0;
            out_data_next.last_row = 1'b1;
        end
        else
        begin
            out_data_next.row_index   = row_wide[IDX_OUT_W-1:0];
            out_data_next.col_index   = col_wide[IDX_OUT_W-1:0];
            out_data_next.match_score = row_rd_score_reg;
            out_data_next.matched     = matched;
            out_data_next.last_row    = last_row;
        end
    end

    assign status.is_query  = (in_data.command == CMD_QUERY);
    assign status.rows_zero = (rows_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/mutual_nearest_match_filter.sv
// Top level of the mutual nearest match filter: controller plus datapath.
// Depends on mnm_pkg, mnm_ctrl, mnm_datapath and the assertion macro header.
//
//   Channel  Signals                        Beat
//   input    in_valid, in_ready, in_data    one score element or one query
//   output   out_valid, out_ready, out_data one row result per query
//   config   cfg_we, cfg_wdata              log threshold write, no wait
//
// A score element reads the column store, then writes it back.
// A query reads the row store, then the column store (skipped when no rows are loaded),
// then the result enters the output register.
// A result waiting in the output register stalls only the next query at its last step.
// Reset clears the counters and the output valid flag and sets the threshold to THR_RESET; the stores need no clearing.
`include "mutual_nearest_match_filter_defines.svh"

module mutual_nearest_match_filter #(
    parameter int MAX_POINTS = mnm_pkg::DEF_MAX_POINTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mnm_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mnm_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic signed [mnm_pkg::SCORE_W-1:0] cfg_wdata
);
    import mnm_pkg::*;

    mnm_cmd_t    cmd;
    mnm_status_t status;

    mnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mnm_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    `MNM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Beat accepted while the previous one was still in work.")
    `MNM_ASSERT_NEXT(a_score_no_result, in_valid && in_ready && (in_data.command == CMD_SCORE), !$rose(out_valid), "A score beat produced a result.")
    `MNM_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready), "A result appeared without a query in work.")

endmodule
